// File: design/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

  // Default sizing: 32-bit values need up to 10 decimal digits
  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned MAX_DIGITS_DEF = 10;

  // Output character width and ASCII code of '0'
  localparam int unsigned CHAR_W     = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  // Converter sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_e;

endpackage

// File: design/binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps

// Binary to decimal ASCII converter.
// Input channel: value_i qualified by in_valid_i; an item is taken on a rising
// edge with in_valid_i high and in_stall_o low. Output channel: one item per
// decimal digit on digit_char_o ('0'..'9'), most significant first, no leading
// zeros (zero gives a single '0'); last_digit_o marks the final digit of a run.
// If the value has more than MAX_DIGITS digits, only the low MAX_DIGITS digits
// are sent, leading zeros included.
// Operation: after the accept edge a bit-serial double dabble takes one input
// bit per cycle, then the BCD register is scanned from the top one digit per
// cycle while the output does not stall, skipping leading zeros and sending
// the rest. One value is in work at a time; in_stall_o is high while it is.
// The last digit sits in an output register, so the next value is accepted
// while that digit still waits. Stalls on the output simply hold the scan.
// Reset (rst_ni low, asynchronous) returns to idle and drops out_valid_o.
module binary_to_decimal_ascii_top
  import b2da_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAR_W-1:0]     digit_char_o,
  output logic                  last_digit_o
);

  localparam int unsigned BCD_W  = 4 * MAX_DIGITS;
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned DCNT_W = $clog2(MAX_DIGITS);

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [CNT_W-1:0]      bit_cnt_q, bit_cnt_d;
  logic [DCNT_W-1:0]     dig_cnt_q, dig_cnt_d;
  logic                  ovf_q, ovf_d;
  logic                  started_q, started_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic [BCD_W-1:0]      bcd_adj;
  logic [3:0]            top_digit;
  logic                  in_accept;
  logic                  out_free;
  logic                  last_slot;
  logic                  emit_now;
  logic                  ovf_next;

  // Double dabble correction: add 3 to every digit of 5 or more
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign last_slot = (dig_cnt_q == '0);
  assign emit_now  = started_q || (top_digit != 4'd0) || last_slot;
  assign ovf_next  = ovf_q || bcd_adj[BCD_W-1];

  // Sequencer: next state, datapath shifts and output register load
  always_comb begin
    state_d     = state_q;
    value_d     = value_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    ovf_d       = ovf_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          value_d   = value_i;
          bcd_d     = '0;
          bit_cnt_d = CNT_W'(VALUE_BITS - 1);
          ovf_d     = 1'b0;
          state_d   = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        // one input bit per cycle, MSB first; carry out of the top digit
        // means the number has more digits than fit
        bcd_d     = {bcd_adj[BCD_W-2:0], value_q[VALUE_BITS-1]};
        value_d   = {value_q[VALUE_BITS-2:0], 1'b0};
        ovf_d     = ovf_next;
        bit_cnt_d = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          dig_cnt_d = DCNT_W'(MAX_DIGITS - 1);
          started_d = ovf_next;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // scan digits from the top; leading zeros are dropped silently
        if (!emit_now) begin
          bcd_d     = {bcd_q[BCD_W-5:0], 4'b0};
          dig_cnt_d = dig_cnt_q - 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ASCII_ZERO + {2'b00, top_digit};
          out_last_d  = last_slot;
          bcd_d       = {bcd_q[BCD_W-5:0], 4'b0};
          dig_cnt_d   = dig_cnt_q - 1'b1;
          started_d   = 1'b1;
          if (last_slot) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      ovf_q       <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      ovf_q       <= ovf_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_digit_o = out_last_q;

  // Assertions

  // a sent character is always a decimal digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o >= ASCII_ZERO) && (digit_char_o <= ASCII_ZERO + 6'd9))
    else $error("digit character out of range");

  // an accepted value starts conversion from a cleared BCD register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_CONVERT) && (bcd_q == '0) && !ovf_q)
    else $error("conversion did not start cleanly");

  // conversion hands over to the scan with a full digit count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONVERT) && (bit_cnt_q == '0)
      |=> (state_q == ST_EMIT) && (dig_cnt_q == DCNT_W'(MAX_DIGITS - 1)))
    else $error("bad handover to digit scan");

  // leading zeros are only skipped when the number fits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && !started_q |-> !ovf_q)
    else $error("digit skipped on an overflowing value");

  // every BCD digit stays a valid decimal digit while in work
  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_bcd_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q != ST_IDLE) |-> (bcd_q[4*g +: 4] <= 4'd9))
      else $error("BCD digit above nine");
  end

endmodule

// File: tb/tb_binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_top;
  import b2da_pkg::*;

  // One expected output digit
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  // Expected digit stream, filled from accepted values, drained by output items
  class digit_scoreboard;
    digit_t      expected_q[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    // Convert an accepted value into its expected digit run
    function void note_value(logic [VALUE_BITS_DEF-1:0] value);
      logic [VALUE_BITS_DEF-1:0] rest;
      logic [3:0]                low_first[$];
      digit_t                    d;
      int                        k;
      rest = value;
      if (rest == '0) begin
        low_first.push_back(4'd0);
      end
      while (rest != '0 && low_first.size() < MAX_DIGITS_DEF) begin
        low_first.push_back(4'(rest % 10));
        rest = rest / 10;
      end
      // most significant digit first; the lowest one ends the run
      for (k = low_first.size() - 1; k >= 0; k--) begin
        d.ch   = ASCII_ZERO + CHAR_W'(low_first[k]);
        d.last = (k == 0);
        expected_q.push_back(d);
      end
    endfunction

    // Compare one output item with the oldest expected digit
    function void check_digit(logic [CHAR_W-1:0] ch, logic last);
      digit_t exp_d;
      if (expected_q.size() == 0) begin
        $error("digit item 0x%0h (last %0b) with nothing expected", ch, last);
        fail_count++;
        return;
      end
      exp_d = expected_q.pop_front();
      if (ch !== exp_d.ch) begin
        $error("digit_char: expected 0x%0h, actual 0x%0h", exp_d.ch, ch);
        fail_count++;
      end
      if (last !== exp_d.last) begin
        $error("last_digit: expected %0b, actual %0b", exp_d.last, last);
        fail_count++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [VALUE_BITS_DEF-1:0] value_i     = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [CHAR_W-1:0]         digit_char_o;
  logic                      last_digit_o;

  digit_scoreboard sb = new();

  // Directed values: extremes, digit-count boundaries, bit patterns
  logic [VALUE_BITS_DEF-1:0] corner_values [0:19] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1000000000, 32'd999999999,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd123456789, 32'd1234567890, 32'd4000000000, 32'd100000,
    32'd10, 32'd0
  };

  binary_to_decimal_ascii_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor both channels at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        sb.note_value(value_i);
      end
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        sb.check_digit(digit_char_o, last_digit_o);
      end
    end
  end

  // Offer one value after an idle gap, hold it until accepted
  task automatic offer_value(input logic [VALUE_BITS_DEF-1:0] value,
                             input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Random value mix: full range, short numbers, powers of ten and the values just below them, shifted values, zero
  function automatic logic [VALUE_BITS_DEF-1:0] draw_value();
    logic [VALUE_BITS_DEF-1:0] p10;
    int unsigned               k;
    k   = $urandom_range(0, 9);
    p10 = 1;
    repeat (k) p10 = p10 * 10;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5:       return $urandom_range(0, 999);
      6:          return p10 - 1;
      7:          return p10;
      8:          return $urandom() >> $urandom_range(0, 31);
      default:    return '0;
    endcase
  endfunction

  // Output side: random stalls, one long hold-off, one stretch without stalls
  initial begin : sink
    int unsigned taken;
    int unsigned hold;
    taken = 0;
    forever begin
      if (taken == 150) begin
        hold = 600;
      end else if (taken >= 400 && taken < 600) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 14);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
      taken++;
    end
  end

  // Reset, directed values, random values, drain, verdict
  initial begin : stim
    int unsigned idx;
    int unsigned gap;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (corner_values[i]) begin
      offer_value(corner_values[i], $urandom_range(0, 14));
    end

    for (idx = 0; idx < 270; idx++) begin
      gap = (idx >= 100 && idx < 140) ? 0 : $urandom_range(0, 14);
      offer_value(draw_value(), gap);
    end
    in_valid_i <= 1'b0;
    // let the monitor record the last accepted value before draining
    @(posedge clk_i);

    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (sb.outstanding() != 0) begin
      $error("%0d expected digits never arrived", sb.outstanding());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
design/b2da_pkg.sv
design/binary_to_decimal_ascii_top.sv
tb/tb_binary_to_decimal_ascii_top.sv
